// File: sv/csv_pkg.sv
`timescale 1ns / 1ps
package csv_pkg;

  // Widths sized for grids of up to 8 divisions (9-bit corner indices) and 3-bit row and column.
  localparam int PW     = 9;   // signed cube-point component
  localparam int LW     = 15;  // squared length
  localparam int SW     = 22;  // square root result
  localparam int XW     = 2 * SW;
  localparam int SQ_SH  = 28;  // the squared length is scaled by 2^28
  localparam int RW     = 26;  // square root remainder
  localparam int QW     = 16;  // normal quotient
  localparam int NUMW   = 37;  // division numerator
  localparam int IDXW   = 9;
  localparam int NMW    = 15;  // normal magnitude after saturation
  localparam int PRW    = 31;  // radius times normal magnitude
  localparam int POSW   = 17;
  localparam int NRMW   = 16;
  localparam logic [QW-1:0] NORM_ONE = 16'd16384;

  typedef logic signed [PW-1:0] comp_t;
  typedef comp_t [2:0] vec_t;

  typedef struct packed {
    logic            face_ok;
    logic            quad_valid;
    logic [IDXW-1:0] base;
    logic [IDXW-1:0] right;
    logic [IDXW-1:0] diag;
    logic [IDXW-1:0] down;
  } meta_t;

  // Per face: corner s0, column axis u, row axis v.
  localparam logic signed [1:0] FACE_TAB [6][3][3] = '{
    '{'{-2'sd1,  2'sd1, -2'sd1}, '{ 2'sd0, -2'sd1, 2'sd0}, '{2'sd0,  2'sd0, 2'sd1}},
    '{'{ 2'sd1, -2'sd1, -2'sd1}, '{ 2'sd0,  2'sd1, 2'sd0}, '{2'sd0,  2'sd0, 2'sd1}},
    '{'{-2'sd1, -2'sd1, -2'sd1}, '{ 2'sd1,  2'sd0, 2'sd0}, '{2'sd0,  2'sd0, 2'sd1}},
    '{'{ 2'sd1,  2'sd1, -2'sd1}, '{-2'sd1,  2'sd0, 2'sd0}, '{2'sd0,  2'sd0, 2'sd1}},
    '{'{-2'sd1,  2'sd1, -2'sd1}, '{ 2'sd1,  2'sd0, 2'sd0}, '{2'sd0, -2'sd1, 2'sd0}},
    '{'{-2'sd1, -2'sd1,  2'sd1}, '{ 2'sd1,  2'sd0, 2'sd0}, '{2'sd0,  2'sd1, 2'sd0}}
  };

endpackage

// File: sv/csv_in_if.sv
`timescale 1ns / 1ps
interface csv_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] face;
  logic [2:0] row;
  logic [2:0] col;

  modport source (output valid, face, row, col, input ready);
  modport sink (input valid, face, row, col, output ready);
endinterface

// File: sv/csv_out_if.sv
`timescale 1ns / 1ps
interface csv_out_if;
  logic              valid;
  logic              ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic              quad_valid;
  logic [8:0]        corner_base;
  logic [8:0]        corner_right;
  logic [8:0]        corner_diag;
  logic [8:0]        corner_down;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, quad_valid,
                  corner_base, corner_right, corner_diag, corner_down, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, quad_valid,
                corner_base, corner_right, corner_diag, corner_down, output ready);
endinterface

// File: sv/csv_front.sv
`timescale 1ns / 1ps
module csv_front #(
  parameter int GRID_DIVISIONS = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2:0]               face,
  input  logic [2:0]               row,
  input  logic [2:0]               col,
  output logic                     out_valid,
  output logic [csv_pkg::LW-1:0]   out_len,
  output csv_pkg::vec_t            out_vec,
  output csv_pkg::meta_t           out_meta
);
  localparam int PW = csv_pkg::PW;
  localparam int W1 = GRID_DIVISIONS + 1;
  localparam int WW = W1 * W1;
  localparam logic signed [PW-1:0] NS = PW'(GRID_DIVISIONS);

  function automatic logic signed [PW-1:0] scl(input logic signed [1:0] k,
                                                input logic signed [PW-1:0] m);
    logic signed [PW-1:0] res;
    res = '0;
    if (k == 2'sd1) res = m;
    else if (k == -2'sd1) res = -m;
    return res;
  endfunction

  logic                   face_ok;
  logic [2:0]             fidx;
  logic signed [PW-1:0]   colx2, rowx2;
  csv_pkg::vec_t          p_nxt;
  csv_pkg::meta_t         meta_nxt;
  logic [15:0]            base_full;
  logic [15:0]            right_full, diag_full, down_full;
  logic                   quad;

  assign face_ok = face <= 3'd5;
  assign fidx    = face_ok ? face : 3'd0;
  assign colx2   = $signed({{(PW-4){1'b0}}, col, 1'b0});
  assign rowx2   = $signed({{(PW-4){1'b0}}, row, 1'b0});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p_nxt[c] = scl(csv_pkg::FACE_TAB[fidx][0][c], NS)
               + scl(csv_pkg::FACE_TAB[fidx][1][c], colx2)
               + scl(csv_pkg::FACE_TAB[fidx][2][c], rowx2);
    end
  end

  assign base_full  = 16'(face) * 16'(WW) + 16'(row) * 16'(W1) + 16'(col);
  assign right_full = base_full + 16'd1;
  assign diag_full  = base_full + 16'(W1 + 1);
  assign down_full  = base_full + 16'(W1);
  assign quad = face_ok && (7'(row) < 7'(GRID_DIVISIONS)) && (7'(col) < 7'(GRID_DIVISIONS));

  always_comb begin
    meta_nxt.face_ok    = face_ok;
    meta_nxt.quad_valid = quad;
    meta_nxt.base       = quad ? base_full[8:0]  : '0;
    meta_nxt.right      = quad ? right_full[8:0] : '0;
    meta_nxt.diag       = quad ? diag_full[8:0]  : '0;
    meta_nxt.down       = quad ? down_full[8:0]  : '0;
  end

  logic                 v1_r, v2_r;
  csv_pkg::vec_t        p1_r, p2_r;
  csv_pkg::meta_t       m1_r, m2_r;
  logic [csv_pkg::LW-1:0] len_r;
  logic signed [2*PW-1:0] sq0, sq1, sq2;

  assign sq0 = p1_r[0] * p1_r[0];
  assign sq1 = p1_r[1] * p1_r[1];
  assign sq2 = p1_r[2] * p1_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= p_nxt;
      m1_r  <= meta_nxt;
      p2_r  <= p1_r;
      m2_r  <= m1_r;
      len_r <= csv_pkg::LW'($unsigned(sq0)) + csv_pkg::LW'($unsigned(sq1))
             + csv_pkg::LW'($unsigned(sq2));
    end
  end

  assign out_valid = v2_r;
  assign out_len   = len_r;
  assign out_vec   = p2_r;
  assign out_meta  = m2_r;
endmodule

// File: sv/csv_sqrt.sv
`timescale 1ns / 1ps
module csv_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [csv_pkg::LW-1:0] in_len,
  input  csv_pkg::vec_t          in_vec,
  input  csv_pkg::meta_t         in_meta,
  output logic                   out_valid,
  output logic [csv_pkg::SW-1:0] out_root,
  output csv_pkg::vec_t          out_vec,
  output csv_pkg::meta_t         out_meta
);
  localparam int SW = csv_pkg::SW;
  localparam int RW = csv_pkg::RW;
  localparam int LW = csv_pkg::LW;
  localparam int XW = csv_pkg::XW;
  localparam int STEPS = SW;

  // One result bit per stage, two radicand bits brought down each time.
  logic [STEPS-1:0] v_r;
  logic [RW-1:0]    rem_r  [STEPS];
  logic [SW-1:0]    root_r [STEPS];
  logic [LW-1:0]    len_r  [STEPS];
  csv_pkg::vec_t    vec_r  [STEPS];
  csv_pkg::meta_t   meta_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_st
    logic           v_i;
    logic [RW-1:0]  rem_i, rem_sh, trial;
    logic [SW-1:0]  root_i;
    logic [LW-1:0]  len_i;
    csv_pkg::vec_t  vec_i;
    csv_pkg::meta_t meta_i;
    logic [XW-1:0]  x;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign root_i = '0;
      assign len_i  = in_len;
      assign vec_i  = in_vec;
      assign meta_i = in_meta;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign len_i  = len_r[k-1];
      assign vec_i  = vec_r[k-1];
      assign meta_i = meta_r[k-1];
    end

    assign x      = XW'({len_i, {csv_pkg::SQ_SH{1'b0}}});
    assign rem_sh = {rem_i[RW-3:0], x[XW-1-2*k -: 2]};
    assign trial  = RW'({root_i, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_i;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_i[SW-2:0], ge};
        len_r[k]  <= len_i;
        vec_r[k]  <= vec_i;
        meta_r[k] <= meta_i;
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_vec   = vec_r[STEPS-1];
  assign out_meta  = meta_r[STEPS-1];
endmodule

// File: sv/csv_div.sv
`timescale 1ns / 1ps
module csv_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [csv_pkg::SW-1:0] in_root,
  input  csv_pkg::vec_t          in_vec,
  input  csv_pkg::meta_t         in_meta,
  output logic                   out_valid,
  output logic [csv_pkg::QW-1:0] out_q [3],
  output logic [2:0]             out_neg,
  output logic                   out_zero,
  output csv_pkg::meta_t         out_meta
);
  localparam int SW = csv_pkg::SW;
  localparam int QW = csv_pkg::QW;
  localparam int NW = csv_pkg::NUMW;
  localparam int PW = csv_pkg::PW;
  localparam int ST = QW + 1;

  // Stage 0 forms |Pc|*2^28 + S/2; the following stages retire one quotient bit each.
  logic [ST-1:0]  v_r;
  logic [NW-1:0]  rem_r  [ST][3];
  logic [QW-1:0]  q_r    [ST][3];
  logic [2:0]     neg_r  [ST];
  logic [SW-1:0]  den_r  [ST];
  csv_pkg::meta_t meta_r [ST];

  logic [PW-1:0] mag0 [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag0[c] = in_vec[c][PW-1] ? PW'(-in_vec[c]) : PW'(in_vec[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (en) v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[0][c] <= NW'({mag0[c], {csv_pkg::SQ_SH{1'b0}}}) + NW'(in_root >> 1);
        q_r[0][c]   <= '0;
        neg_r[0][c] <= in_vec[c][PW-1];
      end
      den_r[0]  <= in_root;
      meta_r[0] <= in_meta;
    end
  end

  for (genvar i = 1; i < ST; i++) begin : g_st
    logic [NW-1:0] dsh;
    logic [2:0]    ge;
    assign dsh = NW'(den_r[i-1]) << (QW - i);
    always_comb begin
      for (int c = 0; c < 3; c++) ge[c] = rem_r[i-1][c] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i] <= 1'b0;
      else if (en) v_r[i] <= v_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          rem_r[i][c] <= ge[c] ? rem_r[i-1][c] - dsh : rem_r[i-1][c];
          q_r[i][c]   <= {q_r[i-1][c][QW-2:0], ge[c]};
        end
        neg_r[i]  <= neg_r[i-1];
        den_r[i]  <= den_r[i-1];
        meta_r[i] <= meta_r[i-1];
      end
    end
  end

  assign out_valid = v_r[ST-1];
  assign out_q     = q_r[ST-1];
  assign out_neg   = neg_r[ST-1];
  assign out_zero  = den_r[ST-1] == '0;
  assign out_meta  = meta_r[ST-1];
endmodule

// File: sv/csv_scale.sv
`timescale 1ns / 1ps
module csv_scale (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [15:0]            radius,
  input  logic                   in_valid,
  input  logic [csv_pkg::QW-1:0] in_q [3],
  input  logic [2:0]             in_neg,
  input  logic                   in_zero,
  input  csv_pkg::meta_t         in_meta,
  csv_out_if.source              out_ch
);
  localparam int NMW  = csv_pkg::NMW;
  localparam int PRW  = csv_pkg::PRW;
  localparam int POSW = csv_pkg::POSW;
  localparam int NRMW = csv_pkg::NRMW;

  logic                  va_r, vb_r, vc_r;
  logic [NMW-1:0]        nmag_r [3];
  logic [2:0]            nega_r, negb_r;
  csv_pkg::meta_t        ma_r, mb_r, mc_r;
  logic [PRW-1:0]        prod_r [3];
  logic signed [NRMW-1:0] nrmb_r [3], nrmc_r [3];
  logic signed [POSW-1:0] pos_r [3];

  logic [NMW-1:0]  nmag_nxt [3];
  logic [PRW:0]    rsum [3];
  logic [POSW-1:0] pmag [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (in_zero || !in_meta.face_ok) nmag_nxt[c] = '0;
      else if (in_q[c] > csv_pkg::NORM_ONE) nmag_nxt[c] = NMW'(csv_pkg::NORM_ONE);
      else nmag_nxt[c] = in_q[c][NMW-1:0];
      rsum[c] = (PRW + 1)'(prod_r[c]) + (PRW + 1)'(14'h2000);
      pmag[c] = rsum[c][14 +: POSW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        nmag_r[c] <= nmag_nxt[c];
        prod_r[c] <= PRW'(radius) * PRW'(nmag_r[c]);
        nrmb_r[c] <= nega_r[c] ? -$signed(NRMW'(nmag_r[c])) : $signed(NRMW'(nmag_r[c]));
        nrmc_r[c] <= nrmb_r[c];
        pos_r[c]  <= negb_r[c] ? -$signed(pmag[c]) : $signed(pmag[c]);
      end
      nega_r <= in_neg;
      negb_r <= nega_r;
      ma_r   <= in_meta;
      mb_r   <= ma_r;
      mc_r   <= mb_r;
    end
  end

  assign out_ch.valid        = vc_r;
  assign out_ch.pos_x        = pos_r[0];
  assign out_ch.pos_y        = pos_r[1];
  assign out_ch.pos_z        = pos_r[2];
  assign out_ch.norm_x       = nrmc_r[0];
  assign out_ch.norm_y       = nrmc_r[1];
  assign out_ch.norm_z       = nrmc_r[2];
  assign out_ch.quad_valid   = mc_r.quad_valid;
  assign out_ch.corner_base  = mc_r.base;
  assign out_ch.corner_right = mc_r.right;
  assign out_ch.corner_diag  = mc_r.diag;
  assign out_ch.corner_down  = mc_r.down;
endmodule

// File: sv/cube_sphere_vertex_generator.sv
// Pipeline stages: 2 front, 22 square root, 17 divide, 3 scale.
// Throughput: one vertex per cycle while the enable is high; the whole pipeline
// advances on one enable that drops only while a finished result waits at the
// output register.
// Reset (synchronous, rst_n low) clears all stage valid bits and sets radius to 128.
`timescale 1ns / 1ps
module cube_sphere_vertex_generator #(
  parameter int GRID_DIVISIONS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  csv_in_if.sink      in_ch,
  csv_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam logic REG_RADIUS = 1'b0;

  logic [15:0] radius_r;
  logic        en;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RADIUS) ? {16'd0, radius_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= 16'd128;
    else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS)
      radius_r <= pwdata[15:0];
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic                   f_v;
  logic [csv_pkg::LW-1:0] f_len;
  csv_pkg::vec_t          f_vec;
  csv_pkg::meta_t         f_meta;

  csv_front #(.GRID_DIVISIONS(GRID_DIVISIONS)) u_front (
    .clk, .rst_n, .en,
    .in_valid(in_ch.valid), .face(in_ch.face), .row(in_ch.row), .col(in_ch.col),
    .out_valid(f_v), .out_len(f_len), .out_vec(f_vec), .out_meta(f_meta)
  );

  logic                   s_v;
  logic [csv_pkg::SW-1:0] s_root;
  csv_pkg::vec_t          s_vec;
  csv_pkg::meta_t         s_meta;

  csv_sqrt u_sqrt (
    .clk, .rst_n, .en,
    .in_valid(f_v), .in_len(f_len), .in_vec(f_vec), .in_meta(f_meta),
    .out_valid(s_v), .out_root(s_root), .out_vec(s_vec), .out_meta(s_meta)
  );

  logic                   d_v;
  logic [csv_pkg::QW-1:0] d_q [3];
  logic [2:0]             d_neg;
  logic                   d_zero;
  csv_pkg::meta_t         d_meta;

  csv_div u_div (
    .clk, .rst_n, .en,
    .in_valid(s_v), .in_root(s_root), .in_vec(s_vec), .in_meta(s_meta),
    .out_valid(d_v), .out_q(d_q), .out_neg(d_neg), .out_zero(d_zero), .out_meta(d_meta)
  );

  csv_scale u_scale (
    .clk, .rst_n, .en, .radius(radius_r),
    .in_valid(d_v), .in_q(d_q), .in_neg(d_neg), .in_zero(d_zero), .in_meta(d_meta),
    .out_ch(out_ch)
  );

  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.norm_x <= 16'sd16384 && out_ch.norm_x >= -16'sd16384))
    else $error("normal x out of range");

  a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.quad_valid) |->
      (out_ch.corner_base == '0 && out_ch.corner_diag == '0))
    else $error("corner index set without a valid quad");

  a_right_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.quad_valid) |->
      (out_ch.corner_right == out_ch.corner_base + 9'd1))
    else $error("right corner index mismatch");
endmodule

// File: tb/cube_sphere_vertex_generator_tb.sv
`timescale 1ns / 1ps
module cube_sphere_vertex_generator_tb;

  localparam int N = 6;
  localparam logic [2:0] RADIUS_ADDR = 3'd0;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic signed [16:0] pos_x, pos_y, pos_z;
    logic signed [15:0] norm_x, norm_y, norm_z;
    logic              quad_valid;
    logic [8:0]        base, right, diag, down;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending[$];
    int      errors;
    int      radius_q;

    function new();
      errors = 0;
      radius_q = 128;
    endfunction

    static function longint isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function longint round_div(longint num, longint den);
      longint m, q;
      m = num < 0 ? -num : num;
      q = (m + den / 2) / den;
      return num < 0 ? -q : q;
    endfunction

    function void note_input(logic [2:0] face, logic [2:0] row, logic [2:0] col);
      vertex_t v;
      longint p[3], len2, s, nv, pv, w, b;
      v = '0;
      if (face <= 3'd5) begin
        len2 = 0;
        for (int c = 0; c < 3; c++) begin
          p[c] = N * csv_pkg::FACE_TAB[face][0][c]
               + 2 * int'(col) * csv_pkg::FACE_TAB[face][1][c]
               + 2 * int'(row) * csv_pkg::FACE_TAB[face][2][c];
          len2 += p[c] * p[c];
        end
        s = isqrt(len2 << 28);
        for (int c = 0; c < 3; c++) begin
          nv = 0;
          pv = 0;
          if (s != 0) begin
            nv = round_div(p[c] <<< 28, s);
            if (nv > 16384) nv = 16384;
            if (nv < -16384) nv = -16384;
            pv = round_div(radius_q * nv, 16384);
          end
          case (c)
            0: begin v.norm_x = nv[15:0]; v.pos_x = pv[16:0]; end
            1: begin v.norm_y = nv[15:0]; v.pos_y = pv[16:0]; end
            default: begin v.norm_z = nv[15:0]; v.pos_z = pv[16:0]; end
          endcase
        end
        if (row < N && col < N) begin
          w = N + 1;
          b = face * w * w + row * w + col;
          v.quad_valid = 1'b1;
          v.base = b[8:0];
          v.right = 9'(b + 1);
          v.diag = 9'(b + w + 1);
          v.down = 9'(b + w);
        end
      end
      pending.push_back(v);
    endfunction

    function void check_result(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_v = pending.pop_front();
      if (got !== exp_v) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %h got %h", exp_v, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  csv_in_if in_ch();
  csv_out_if out_ch();

  cube_sphere_vertex_generator #(.GRID_DIVISIONS(N)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vertex_scoreboard sb;
  int  cycles;
  bit  long_hold;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_radius(logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RADIUS_ADDR;
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.radius_q = value;
  endtask

  // Keeps valid high across back-to-back transfers when there is no gap.
  task automatic send_vertex(logic [2:0] face, logic [2:0] row, logic [2:0] col,
                             bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.face <= face;
    in_ch.row <= row;
    in_ch.col <= col;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(face, row, col);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int count, bit allow_gap);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0)
        send_vertex(3'($urandom_range(6, 7)), 3'($urandom), 3'($urandom), allow_gap);
      else if (r == 1)
        send_vertex(3'($urandom_range(0, 5)), 3'($urandom), 3'($urandom), allow_gap);
      else
        send_vertex(3'($urandom_range(0, 5)), 3'($urandom_range(0, N)),
                    3'($urandom_range(0, N)), allow_gap);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while the sender keeps going.
  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    while (1) begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.norm_x,
                       out_ch.norm_y, out_ch.norm_z, out_ch.quad_valid,
                       out_ch.corner_base, out_ch.corner_right, out_ch.corner_diag,
                       out_ch.corner_down});
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] radii[5];
    sb = new();
    cycles = 0;
    long_hold = 0;
    rst_n = 1'b0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.face = '0;
    in_ch.row = '0;
    in_ch.col = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset radius, two opposite corners of every face, extrapolated points, bad faces.
    for (int f = 0; f < 6; f++) begin
      send_vertex(3'(f), 3'd0, 3'd0, 0);
      send_vertex(3'(f), 3'(N), 3'(N), 0);
    end
    send_vertex(3'd0, 3'd7, 3'd7, 0);
    send_vertex(3'd5, 3'd7, 3'd0, 0);
    send_vertex(3'd2, 3'd0, 3'd7, 0);
    send_vertex(3'd3, 3'd3, 3'd3, 0);
    send_vertex(3'd4, 3'd5, 3'd5, 0);
    send_vertex(3'd6, 3'd2, 3'd2, 0);
    send_vertex(3'd7, 3'd7, 3'd7, 0);
    drain();

    radii = '{16'hFFFF, 16'd0, 16'd1, 16'h8000, 16'd0};
    radii[4] = 16'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      write_radius(radii[ph]);
      if (ph == 2) begin
        long_hold = 1;
        random_phase(300, 0);
      end
      random_phase(ph == 2 ? 50 : 350, 1);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/csv_pkg.sv
sv/csv_in_if.sv
sv/csv_out_if.sv
sv/csv_front.sv
sv/csv_sqrt.sv
sv/csv_div.sv
sv/csv_scale.sv
sv/cube_sphere_vertex_generator.sv
tb/cube_sphere_vertex_generator_tb.sv
